// File: rtl/circumcircle_three_points_macros.svh
// Assertion macros shared by the circumcircle design; they expect clk and rst_n in scope.
`ifndef CIRCUMCIRCLE_THREE_POINTS_MACROS_SVH
`define CIRCUMCIRCLE_THREE_POINTS_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ccirc_pkg.sv
// Shared types and constants of the circumcircle block.
package ccirc_pkg;

    localparam int OUT_WIDTH  = 32;
    localparam int MIDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] center_x;
        logic [OUT_WIDTH-1:0] center_y;
        logic [OUT_WIDTH-1:0] radius;
        logic                 collinear;
        logic                 saturated;
    } res_t;

endpackage

// File: rtl/ccirc_fifo.sv
// Small register-based queue used between the front, the back and the result ports.
module ccirc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   pop,
    input  logic [WIDTH-1:0]       wdata,
    output logic [WIDTH-1:0]       rdata,
    output ccirc_pkg::q_status_t   status
);
    import ccirc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata        = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (AW+1)'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// File: rtl/ccirc_front.sv
// Front pipeline: relative coordinates, cross product, side lengths and center numerators.
module ccirc_front #(
    parameter int COORD_WIDTH = 12,
    parameter int DW  = COORD_WIDTH + 1,
    parameter int XW  = 3 * DW + 1,
    parameter int DVW = 2 * DW + 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by_coord,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    output logic                          out_valid,
    output logic signed [COORD_WIDTH-1:0] o_ax,
    output logic signed [COORD_WIDTH-1:0] o_ay,
    output logic [XW-1:0]                 mx,
    output logic [XW-1:0]                 my,
    output logic                          negx,
    output logic                          negy,
    output logic [DVW-1:0]                den,
    output logic                          collinear
);
    import ccirc_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = 2 * DW;
    localparam int CRW = 2 * DW + 1;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [CW-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, cx1_reg, cy1_reg;
    logic signed [CW-1:0] ax2_reg, ay2_reg, ax3_reg, ay3_reg, ax4_reg, ay4_reg;
    logic signed [CW-1:0] ax5_reg, ay5_reg;
    logic signed [DW-1:0] bxr2_reg, byr2_reg, cxr2_reg, cyr2_reg;
    logic signed [DW-1:0] bxr3_reg, byr3_reg, cxr3_reg, cyr3_reg;
    logic signed [DW-1:0] bxr4_reg, byr4_reg, cxr4_reg, cyr4_reg;
    logic signed [PW-1:0] pa3_reg, pb3_reg, sbx3_reg, sby3_reg, scx3_reg, scy3_reg;
    logic signed [CRW-1:0] cross4_reg;
    logic [PW-1:0]        nb4_reg, nc4_reg;
    logic signed [XW-1:0] px1_reg, px2_reg, py1_reg, py2_reg;
    logic                 coll5_reg, cneg5_reg;
    logic [DVW-1:0]       den5_reg;
    logic [CRW-1:0]       abs_cross;
    logic signed [XW-1:0] nx, ny;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign abs_cross = cross4_reg[CRW-1] ? CRW'(-cross4_reg) : CRW'(cross4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg <= ax;
            ay1_reg <= ay;
            bx1_reg <= bx;
            by1_reg <= by_coord;
            cx1_reg <= cx;
            cy1_reg <= cy;

            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            bxr2_reg <= DW'(bx1_reg) - DW'(ax1_reg);
            byr2_reg <= DW'(by1_reg) - DW'(ay1_reg);
            cxr2_reg <= DW'(cx1_reg) - DW'(ax1_reg);
            cyr2_reg <= DW'(cy1_reg) - DW'(ay1_reg);

            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            bxr3_reg <= bxr2_reg;
            byr3_reg <= byr2_reg;
            cxr3_reg <= cxr2_reg;
            cyr3_reg <= cyr2_reg;
            pa3_reg  <= bxr2_reg * cyr2_reg;
            pb3_reg  <= byr2_reg * cxr2_reg;
            sbx3_reg <= bxr2_reg * bxr2_reg;
            sby3_reg <= byr2_reg * byr2_reg;
            scx3_reg <= cxr2_reg * cxr2_reg;
            scy3_reg <= cyr2_reg * cyr2_reg;

            ax4_reg    <= ax3_reg;
            ay4_reg    <= ay3_reg;
            bxr4_reg   <= bxr3_reg;
            byr4_reg   <= byr3_reg;
            cxr4_reg   <= cxr3_reg;
            cyr4_reg   <= cyr3_reg;
            cross4_reg <= CRW'(pa3_reg) - CRW'(pb3_reg);
            nb4_reg    <= $unsigned(sbx3_reg) + $unsigned(sby3_reg);
            nc4_reg    <= $unsigned(scx3_reg) + $unsigned(scy3_reg);

            ax5_reg   <= ax4_reg;
            ay5_reg   <= ay4_reg;
            px1_reg   <= cyr4_reg * $signed({1'b0, nb4_reg});
            px2_reg   <= byr4_reg * $signed({1'b0, nc4_reg});
            py1_reg   <= bxr4_reg * $signed({1'b0, nc4_reg});
            py2_reg   <= cxr4_reg * $signed({1'b0, nb4_reg});
            coll5_reg <= (cross4_reg == '0);
            cneg5_reg <= cross4_reg[CRW-1];
            // The divisor is four times the magnitude of the cross product.
            den5_reg  <= {abs_cross, 2'b00};
        end
    end

    assign nx = px1_reg - px2_reg;
    assign ny = py1_reg - py2_reg;

    assign out_valid = v5_reg;
    assign o_ax      = ax5_reg;
    assign o_ay      = ay5_reg;
    assign mx        = nx[XW-1] ? XW'(-nx) : XW'(nx);
    assign my        = ny[XW-1] ? XW'(-ny) : XW'(ny);
    assign negx      = nx[XW-1] ^ cneg5_reg;
    assign negy      = ny[XW-1] ^ cneg5_reg;
    assign den       = den5_reg;
    assign collinear = coll5_reg;

endmodule

// File: rtl/ccirc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ccirc_div #(
    parameter int NUMW = 50,
    parameter int DVW  = 29
) (
    input  logic            clk,
    input  logic            en,
    input  logic [NUMW-1:0] num,
    input  logic [DVW-1:0]  den,
    output logic [NUMW-1:0] quo
);
    import ccirc_pkg::*;

    logic [NUMW-1:0] nq_reg  [NUMW];
    logic [DVW-1:0]  rem_reg [NUMW];
    logic [DVW-1:0]  d_reg   [NUMW];
    logic [NUMW-1:0] nq_in   [NUMW];
    logic [DVW-1:0]  rem_in  [NUMW];
    logic [DVW-1:0]  d_in    [NUMW];
    logic [NUMW-1:0] nq_next [NUMW];
    logic [DVW-1:0]  rem_next[NUMW];

    assign nq_in[0]  = num;
    assign rem_in[0] = '0;
    assign d_in[0]   = den;

    for (genvar k = 1; k < NUMW; k++)
    begin : g_link
        assign nq_in[k]  = nq_reg[k-1];
        assign rem_in[k] = rem_reg[k-1];
        assign d_in[k]   = d_reg[k-1];
    end

    always_comb
    begin
        logic [DVW:0] rr;
        logic         ge;
        for (int k = 0; k < NUMW; k++)
        begin
            rr = {rem_in[k], nq_in[k][NUMW-1]};
            ge = (rr >= {1'b0, d_in[k]});
            rem_next[k] = ge ? DVW'(rr - {1'b0, d_in[k]}) : rr[DVW-1:0];
            nq_next[k]  = {nq_in[k][NUMW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUMW; k++)
            begin
                nq_reg[k]  <= nq_next[k];
                rem_reg[k] <= rem_next[k];
                d_reg[k]   <= d_in[k];
            end
        end
    end

    assign quo = nq_reg[NUMW-1];

endmodule

// File: rtl/ccirc_isqrt.sv
// Pipelined integer square root of a 64-bit word, one root bit per stage.
module ccirc_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] s,
    output logic [31:0] root,
    output logic [63:0] rem
);
    import ccirc_pkg::*;

    localparam int STEPS = 32;

    logic [63:0] n_reg   [STEPS];
    logic [63:0] r_reg   [STEPS];
    logic [63:0] n_in    [STEPS];
    logic [63:0] r_in    [STEPS];
    logic [63:0] n_next  [STEPS];
    logic [63:0] r_next  [STEPS];

    assign n_in[0] = s;
    assign r_in[0] = '0;

    for (genvar k = 1; k < STEPS; k++)
    begin : g_link
        assign n_in[k] = n_reg[k-1];
        assign r_in[k] = r_reg[k-1];
    end

    always_comb
    begin
        logic [63:0] bitv;
        logic [63:0] t;
        for (int k = 0; k < STEPS; k++)
        begin
            bitv = 64'd1 << (62 - 2 * k);
            t    = r_in[k] + bitv;
            if (n_in[k] >= t)
            begin
                n_next[k] = n_in[k] - t;
                r_next[k] = (r_in[k] >> 1) + bitv;
            end
            else
            begin
                n_next[k] = n_in[k];
                r_next[k] = r_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                n_reg[k] <= n_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = r_reg[STEPS-1][31:0];
    assign rem  = n_reg[STEPS-1];

endmodule

// File: rtl/ccirc_back.sv
// Back pipeline: rounded division, center offset and saturation, radius by square root.
module ccirc_back #(
    parameter int COORD_WIDTH = 12,
    parameter int FRAC_BITS   = 8,
    parameter int DW  = COORD_WIDTH + 1,
    parameter int XW  = 3 * DW + 1,
    parameter int DVW = 2 * DW + 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic [XW-1:0]                 mx,
    input  logic [XW-1:0]                 my,
    input  logic                          negx,
    input  logic                          negy,
    input  logic [DVW-1:0]                den,
    input  logic                          collinear,
    output logic                          out_valid,
    output ccirc_pkg::res_t               res
);
    import ccirc_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int NUMW  = XW + FRAC_BITS + 2;
    localparam int SW    = NUMW + 2;
    localparam int CEW   = (SW > 33) ? SW : 33;
    localparam int QEW   = (NUMW > 33) ? NUMW : 33;
    localparam int SQRTS = 32;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic                 negx;
        logic                 negy;
        logic                 coll;
    } dsb_t;

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic        satc;
        logic        radsat;
        logic        coll;
    } ssb_t;

    logic            v0_reg;
    dsb_t            sb0_reg;
    logic [XW-1:0]   mx0_reg, my0_reg;
    logic [DVW-1:0]  den0_reg;
    logic [NUMW-1:0] numx, numy, qx, qy;

    logic            dv_reg [NUMW];
    dsb_t            dsb_reg[NUMW];

    logic            v1_reg, v2_reg, v3_reg;
    logic [31:0]     cx1_reg, cy1_reg, mx1_reg, my1_reg;
    logic            satc1_reg, big1_reg, coll1_reg;
    logic [31:0]     cx2_reg, cy2_reg;
    logic            satc2_reg, big2_reg, coll2_reg;
    logic [63:0]     sqx2_reg, sqy2_reg;
    ssb_t            sb3_reg;
    logic [63:0]     s3_reg;

    logic            sv_reg [SQRTS];
    ssb_t            ssb_reg[SQRTS];

    logic signed [NUMW:0] uxq, uyq, ux, uy;
    logic signed [SW-1:0] sumx, sumy;
    logic [31:0]     satx, saty;
    logic            ovx, ovy;
    logic [QEW-1:0]  qxe, qye;
    logic [64:0]     s_sum;
    logic [31:0]     root;
    logic [63:0]     rem;
    logic [31:0]     rad;
    dsb_t            dsb_last;
    ssb_t            ssb_last;

    function automatic logic [31:0] sat32(input logic signed [SW-1:0] v, output logic ov);
        logic signed [CEW-1:0] e;
        logic                  fits;
        e    = CEW'(v);
        fits = (&e[CEW-1:31]) | ~(|e[CEW-1:31]);
        ov   = ~fits;
        return fits ? e[31:0] : (e[CEW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    endfunction

    // Rounded quotient: (|n| * 2^(F+1) + den/2) / den, where den is four times the cross product.
    assign numx = (NUMW'(mx0_reg) << (FRAC_BITS + 1)) + NUMW'(den0_reg >> 1);
    assign numy = (NUMW'(my0_reg) << (FRAC_BITS + 1)) + NUMW'(den0_reg >> 1);

    ccirc_div #(.NUMW(NUMW), .DVW(DVW)) u_div_x (
        .clk (clk),
        .en  (en),
        .num (numx),
        .den (den0_reg),
        .quo (qx)
    );

    ccirc_div #(.NUMW(NUMW), .DVW(DVW)) u_div_y (
        .clk (clk),
        .en  (en),
        .num (numy),
        .den (den0_reg),
        .quo (qy)
    );

    assign dsb_last = dsb_reg[NUMW-1];
    assign uxq  = $signed({1'b0, qx});
    assign uyq  = $signed({1'b0, qy});
    assign ux   = dsb_last.negx ? -uxq : uxq;
    assign uy   = dsb_last.negy ? -uyq : uyq;
    assign sumx = SW'(ux) + (SW'(dsb_last.ax) <<< FRAC_BITS);
    assign sumy = SW'(uy) + (SW'(dsb_last.ay) <<< FRAC_BITS);
    assign qxe  = QEW'(qx);
    assign qye  = QEW'(qy);

    always_comb
    begin
        satx = sat32(sumx, ovx);
        saty = sat32(sumy, ovy);
    end

    assign s_sum = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};

    ccirc_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .s    (s3_reg),
        .root (root),
        .rem  (rem)
    );

    assign ssb_last = ssb_reg[SQRTS-1];

    always_comb
    begin
        rad = root + 32'(rem > {32'd0, root});
        if (ssb_last.radsat)
        begin
            rad = 32'hFFFF_FFFF;
        end
        if (ssb_last.coll)
        begin
            res.center_x  = '0;
            res.center_y  = '0;
            res.radius    = '0;
            res.collinear = 1'b1;
            res.saturated = 1'b0;
        end
        else
        begin
            res.center_x  = ssb_last.cx;
            res.center_y  = ssb_last.cy;
            res.radius    = rad;
            res.collinear = 1'b0;
            res.saturated = ssb_last.satc | ssb_last.radsat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k < NUMW; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
            for (int k = 0; k < SQRTS; k++)
            begin
                sv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg    <= in_valid;
            dv_reg[0] <= v0_reg;
            for (int k = 1; k < NUMW; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            v1_reg    <= dv_reg[NUMW-1];
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            sv_reg[0] <= v3_reg;
            for (int k = 1; k < SQRTS; k++)
            begin
                sv_reg[k] <= sv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb0_reg.ax   <= ax;
            sb0_reg.ay   <= ay;
            sb0_reg.negx <= negx;
            sb0_reg.negy <= negy;
            sb0_reg.coll <= collinear;
            mx0_reg      <= mx;
            my0_reg      <= my;
            den0_reg     <= den;

            dsb_reg[0] <= sb0_reg;
            for (int k = 1; k < NUMW; k++)
            begin
                dsb_reg[k] <= dsb_reg[k-1];
            end

            cx1_reg   <= satx;
            cy1_reg   <= saty;
            satc1_reg <= ovx | ovy;
            big1_reg  <= (|qxe[QEW-1:32]) | (|qye[QEW-1:32]);
            mx1_reg   <= qxe[31:0];
            my1_reg   <= qye[31:0];
            coll1_reg <= dsb_last.coll;

            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            satc2_reg <= satc1_reg;
            big2_reg  <= big1_reg;
            coll2_reg <= coll1_reg;
            sqx2_reg  <= mx1_reg * mx1_reg;
            sqy2_reg  <= my1_reg * my1_reg;

            sb3_reg.cx     <= cx2_reg;
            sb3_reg.cy     <= cy2_reg;
            sb3_reg.satc   <= satc2_reg;
            sb3_reg.radsat <= big2_reg | s_sum[64] | (s_sum[63:0] > 64'hFFFF_FFFF_0000_0000);
            sb3_reg.coll   <= coll2_reg;
            s3_reg         <= s_sum[63:0];

            ssb_reg[0] <= sb3_reg;
            for (int k = 1; k < SQRTS; k++)
            begin
                ssb_reg[k] <= ssb_reg[k-1];
            end
        end
    end

    assign out_valid = sv_reg[SQRTS-1];

endmodule

// File: rtl/circumcircle_three_points.sv
// Circumcircle of three points, from accepted word to queued result.
// One word is taken per cycle and one result given per cycle when the result side keeps up;
// the per-bit divider and square root pipelines set the latency.
// The front stalls only when the middle queue is full, the back only when the result queue is.
// Reset (rst_n low, asynchronous) empties both queues and all pipeline valid bits.
module circumcircle_three_points #(
    parameter int COORD_WIDTH = 12,
    parameter int FRAC_BITS   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by_coord,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [31:0]            center_x,
    output logic signed [31:0]            center_y,
    output logic [31:0]                   radius,
    output logic                          collinear,
    output logic                          saturated
);
    import ccirc_pkg::*;
    `include "circumcircle_three_points_macros.svh"

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;
    localparam int XW  = 3 * DW + 1;
    localparam int DVW = 2 * DW + 3;
    localparam int MQW = 2 * CW + 2 * XW + 2 + DVW + 1;
    localparam int RW  = $bits(res_t);

    logic            front_en, back_en;
    logic            f_valid, f_negx, f_negy, f_coll;
    logic signed [CW-1:0] f_ax, f_ay, b_ax, b_ay;
    logic [XW-1:0]   f_mx, f_my, b_mx, b_my;
    logic [DVW-1:0]  f_den, b_den;
    logic            b_negx, b_negy, b_coll;
    logic            mq_push, mq_pop, oq_push;
    logic [MQW-1:0]  mq_wdata, mq_rdata;
    q_status_t       mq_status, oq_status;
    logic            b_valid;
    res_t            b_res, o_res;
    logic [RW-1:0]   oq_rdata;

    assign front_en = !mq_status.full;
    assign full     = mq_status.full;

    ccirc_front #(.COORD_WIDTH(CW), .DW(DW), .XW(XW), .DVW(DVW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (front_en),
        .in_valid  (push),
        .ax        (ax),
        .ay        (ay),
        .bx        (bx),
        .by_coord  (by_coord),
        .cx        (cx),
        .cy        (cy),
        .out_valid (f_valid),
        .o_ax      (f_ax),
        .o_ay      (f_ay),
        .mx        (f_mx),
        .my        (f_my),
        .negx      (f_negx),
        .negy      (f_negy),
        .den       (f_den),
        .collinear (f_coll)
    );

    assign mq_push  = front_en && f_valid;
    assign mq_wdata = {f_ax, f_ay, f_mx, f_my, f_negx, f_negy, f_den, f_coll};

    ccirc_fifo #(.WIDTH(MQW), .DEPTH(MIDQ_DEPTH)) u_midq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (mq_push),
        .pop    (mq_pop),
        .wdata  (mq_wdata),
        .rdata  (mq_rdata),
        .status (mq_status)
    );

    assign back_en = !oq_status.full;
    assign mq_pop  = back_en && !mq_status.empty;
    assign {b_ax, b_ay, b_mx, b_my, b_negx, b_negy, b_den, b_coll} = mq_rdata;

    ccirc_back #(
        .COORD_WIDTH (CW),
        .FRAC_BITS   (FRAC_BITS),
        .DW          (DW),
        .XW          (XW),
        .DVW         (DVW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (mq_pop),
        .ax        (b_ax),
        .ay        (b_ay),
        .mx        (b_mx),
        .my        (b_my),
        .negx      (b_negx),
        .negy      (b_negy),
        .den       (b_den),
        .collinear (b_coll),
        .out_valid (b_valid),
        .res       (b_res)
    );

    assign oq_push = back_en && b_valid;

    ccirc_fifo #(.WIDTH(RW), .DEPTH(OUTQ_DEPTH)) u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (oq_push),
        .pop    (pop && !oq_status.empty),
        .wdata  (b_res),
        .rdata  (oq_rdata),
        .status (oq_status)
    );

    assign o_res     = res_t'(oq_rdata);
    assign empty     = oq_status.empty;
    assign center_x  = o_res.center_x;
    assign center_y  = o_res.center_y;
    assign radius    = o_res.radius;
    assign collinear = o_res.collinear;
    assign saturated = o_res.saturated;

    `CC_ASSERT_IMPL(a_coll_zero, !empty && collinear,
        center_x == 0 && center_y == 0 && radius == 0 && !saturated,
        "collinear word carries a nonzero circle")
    `CC_ASSERT_IMPL(a_midq_underrun, mq_pop, !mq_status.empty, "middle queue popped while empty")
    `CC_ASSERT_IMPL(a_outq_overrun, oq_push, !oq_status.full, "result queue written while full")

endmodule

// File: bench/circumcircle_three_points_tb.sv
// Self-checking testbench of the circumcircle block, with its own exact predictor.
module circumcircle_three_points_tb;

    localparam int CW = 12;
    localparam int FB = 8;
    localparam int LATENCY = 3 * CW + FB + 49;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [31:0]        rad;
        logic               col;
        logic               sat;
    } circle_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic signed [CW-1:0] ax = '0, ay = '0, bx = '0, by_coord = '0, cx = '0, cy = '0;
    logic signed [31:0] center_x, center_y;
    logic [31:0] radius;
    logic collinear, saturated;

    circle_t expected_circles[$];
    int  errors = 0;
    int  hold_cycles = 0;
    bit  sender_busy = 1'b0;

    circumcircle_three_points #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord), .cx(cx), .cy(cy),
        .empty(empty), .pop(pop), .center_x(center_x), .center_y(center_y),
        .radius(radius), .collinear(collinear), .saturated(saturated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Rounded quotient of n*2^FB/d, ties away from zero.
    function automatic logic signed [127:0] scaled_quotient(logic signed [127:0] n,
                                                            logic signed [127:0] d);
        logic signed [127:0] nm, dm, q;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        q = ((nm <<< (FB + 1)) + dm) / (2 * dm);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic logic [31:0] clip_signed(logic signed [127:0] v, ref bit sat);
        if (v > 128'sh7FFFFFFF)
        begin
            sat = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (v < -128'sh80000000)
        begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic circle_t predict_circle(logic signed [CW-1:0] pax, pay, pbx, pby,
                                               pcx, pcy);
        circle_t r;
        logic signed [127:0] bxr, byr, cxr, cyr, crs, nb, nc, ux, uy, s, root;
        bit sat;
        sat = 1'b0;
        bxr = pbx - pax;
        byr = pby - pay;
        cxr = pcx - pax;
        cyr = pcy - pay;
        crs = bxr * cyr - byr * cxr;
        r = '{0, 0, 0, 1'b1, 1'b0};
        if (crs == 0)
            return r;
        nb = bxr * bxr + byr * byr;
        nc = cxr * cxr + cyr * cyr;
        ux = scaled_quotient(cyr * nb - byr * nc, 2 * crs);
        uy = scaled_quotient(bxr * nc - cxr * nb, 2 * crs);
        r.cx = clip_signed(ux + (128'(pax) <<< FB), sat);
        r.cy = clip_signed(uy + (128'(pay) <<< FB), sat);
        s = ux * ux + uy * uy;
        if (s > 128'sh0000_0000_0000_0000_FFFF_FFFF_0000_0000)
        begin
            r.rad = 32'hFFFFFFFF;
            sat = 1'b1;
        end
        else
        begin
            root = 0;
            for (int b = 31; b >= 0; b--)
                if ((root + (128'sd1 <<< b)) * (root + (128'sd1 <<< b)) <= s)
                    root = root + (128'sd1 <<< b);
            if (s - root * root > root)
                root = root + 1;
            r.rad = root[31:0];
        end
        r.col = 1'b0;
        r.sat = sat;
        return r;
    endfunction

    task automatic send_triangle(int pax, pay, pbx, pby, pcx, pcy);
        ax <= CW'(pax); ay <= CW'(pay); bx <= CW'(pbx);
        by_coord <= CW'(pby); cx <= CW'(pcx); cy <= CW'(pcy);
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        expected_circles.push_back(predict_circle(CW'(pax), CW'(pay), CW'(pbx),
                                                  CW'(pby), CW'(pcx), CW'(pcy)));
        @(negedge clk);
        // Mostly back-to-back words, sometimes a short or long gap.
        if ($urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
                @(negedge clk);
        end
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        return $urandom_range(0, 4) == 0 ? (($urandom_range(0, 1)) ? 12'sh7FF : 12'sh800)
                                          : CW'($urandom);
    endfunction

    task automatic test_directed();
        send_triangle(0, 0, 0, 0, 0, 0);
        send_triangle(1, 1, 2, 2, 3, 3);
        send_triangle(-5, 7, -5, 7, 100, 3);
        send_triangle(0, 0, 4, 0, 0, 3);
        send_triangle(0, 0, 1, 0, 0, 1);
        send_triangle(0, 0, 1, 0, 1, 1);
        send_triangle(0, 0, 3, 0, 1, 1);
        send_triangle(-2048, -2048, 2047, -2048, -2048, 2047);
        send_triangle(2047, 2047, -2048, 2047, 2047, -2048);
        send_triangle(-2048, -2048, 2047, 2047, 2047, 2046);
        send_triangle(-2048, 0, 2047, 0, 0, 1);
        send_triangle(0, -2048, 0, 2047, 1, 0);
        send_triangle(2047, -2048, -2048, 2047, 0, 0);
        send_triangle(-2048, 2047, 2047, -2048, 1, 1);
        send_triangle(10, 10, 11, 12, 12, 14);
        send_triangle(-1, -1, 1, 1, -1, 1);
        send_triangle(1365, -1366, -1366, 1365, 291, -292);
    endtask

    task automatic test_random();
        logic signed [CW-1:0] p[6];
        for (int i = 0; i < 1130; i++)
        begin
            foreach (p[k])
                p[k] = rand_coord();
            case ($urandom_range(0, 7))
                0: begin p[4] = p[0]; p[5] = p[1]; end
                1:
                begin
                    p[2] = CW'(p[0] + 2 * (p[4] - p[0]));
                    p[3] = CW'(p[1] + 2 * (p[5] - p[1]));
                end
                2:
                begin
                    p[2] = CW'(p[0] + 1); p[3] = p[1];
                    p[4] = p[0]; p[5] = CW'(p[1] + 1);
                end
                3: begin p[2] = p[0] + CW'($urandom_range(0, 7)); p[3] = CW'(p[1] + 1); end
                default: ;
            endcase
            send_triangle(int'(p[0]), int'(p[1]), int'(p[2]), int'(p[3]),
                          int'(p[4]), int'(p[5]));
        end
    endtask

    // The reader stops long enough for the block to fill and raise full.
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 150; i++)
            send_triangle(int'(rand_coord()), int'(rand_coord()), int'(rand_coord()),
                          int'(rand_coord()), int'(rand_coord()), int'(rand_coord()));
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(0, 49) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        circle_t e;
        if (rst_n && pop && !empty)
        begin
            if (expected_circles.size() == 0)
            begin
                $display("%0t: unexpected word cx=%0d cy=%0d r=%0d", $time, center_x,
                         center_y, radius);
                errors++;
            end
            else
            begin
                e = expected_circles.pop_front();
                if (center_x !== e.cx)
                begin
                    $display("%0t: center_x exp %0d got %0d", $time, e.cx, center_x);
                    errors++;
                end
                if (center_y !== e.cy)
                begin
                    $display("%0t: center_y exp %0d got %0d", $time, e.cy, center_y);
                    errors++;
                end
                if (radius !== e.rad)
                begin
                    $display("%0t: radius exp %0d got %0d", $time, e.rad, radius);
                    errors++;
                end
                if (collinear !== e.col)
                begin
                    $display("%0t: collinear exp %0b got %0b", $time, e.col, collinear);
                    errors++;
                end
                if (saturated !== e.sat)
                begin
                    $display("%0t: saturated exp %0b got %0b", $time, e.sat, saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("circumcircle_three_points_tb NOT OK");
        $finish;
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random();
        push <= 1'b0;
        while (expected_circles.size() != 0)
            @(negedge clk);
        repeat (2 * LATENCY) @(negedge clk);
        if (errors == 0 && expected_circles.size() == 0)
            $display("circumcircle_three_points_tb OK");
        else
            $display("circumcircle_three_points_tb NOT OK");
        $finish;
    end

endmodule
